/* rtl/core/id3fx_pkg.sv */
// Package: shared types and constants for the ID3v2 frame extractor.
package id3fx_pkg;

    localparam int unsigned TAG_W   = 28;
    localparam int unsigned POS_W   = 29;
    localparam int unsigned IDENT_W = 32;
    localparam int unsigned BYTE_W  = 8;

    localparam logic [POS_W-1:0] HDR_SIZE_FIRST = 29'd6;
    localparam logic [POS_W-1:0] HDR_SIZE_LAST  = 29'd9;
    localparam logic [POS_W-1:0] TAG_HDR_LEN    = 29'd10;
    localparam logic [POS_W-1:0] POS_MAX        = {POS_W{1'b1}};

    localparam logic [1:0] FIELD_LAST_4 = 2'd3;
    localparam logic [1:0] FIELD_LAST_3 = 2'd2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam logic REG_MATCH_KEY = 1'b0;
    localparam logic REG_SHOW_ALL  = 1'b1;

    typedef enum logic [2:0] {
        PH_HEAD  = 3'd0,
        PH_ID    = 3'd1,
        PH_SIZE  = 3'd2,
        PH_FLAGS = 3'd3,
        PH_DATA  = 3'd4
    } t_phase;

    typedef struct packed {
        logic               kind;
        logic [BYTE_W-1:0]  payload_byte;
        logic [IDENT_W-1:0] frame_ident;
        logic               frame_last;
        logic               key_found;
        logic               truncated;
    } t_result;

endpackage

/* rtl/core/id3fx_parser.sv */
// Input word register and per-byte tag parsing state machine.
module id3fx_parser
    import id3fx_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [BYTE_W-1:0]  i_data_byte,
    input  logic               i_stream_end,
    input  logic [IDENT_W-1:0] i_match_key,
    input  logic               i_show_all,
    input  logic               i_load_ok,
    output logic               o_res_valid,
    output t_result            o_res
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_end;

    t_phase             r_phase,        n_phase;
    logic [1:0]         r_field_count,  n_field_count;
    logic [TAG_W-1:0]   r_tag_length,   n_tag_length;
    logic [POS_W-1:0]   r_position,     n_position;
    logic [IDENT_W-1:0] r_ident,        n_ident;
    logic [TAG_W-1:0]   r_payload_left, n_payload_left;
    logic               r_found,        n_found;
    logic               r_done,         n_done;

    logic               fire;
    logic               accept;
    logic               emit;
    logic               ended;
    logic [6:0]         b7;
    logic [POS_W-1:0]   tag_end;
    logic [TAG_W-1:0]   size_acc;
    t_result            res;

    assign fire    = r_in_valid && i_load_ok;
    assign o_stall = r_in_valid && !fire;
    assign accept  = i_valid && !o_stall;
    assign b7      = r_in_byte[6:0];
    assign tag_end = {1'b0, r_tag_length} + TAG_HDR_LEN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_stream_end;
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_field_count  = r_field_count;
        n_tag_length   = r_tag_length;
        n_position     = r_position;
        n_ident        = r_ident;
        n_payload_left = r_payload_left;
        n_found        = r_found;
        n_done         = r_done;
        emit           = 1'b0;
        ended          = 1'b0;
        size_acc       = {r_payload_left[TAG_W-8:0], b7};
        res            = '0;

        if (!r_done) begin
            if (r_position != POS_MAX) begin
                n_position = r_position + 1'b1;
            end
            case (r_phase)
                PH_HEAD: begin
                    if (r_position >= HDR_SIZE_FIRST) begin
                        n_tag_length = {r_tag_length[TAG_W-8:0], b7};
                    end
                    if (r_position >= HDR_SIZE_LAST) begin
                        n_phase       = PH_ID;
                        n_field_count = '0;
                    end
                end
                PH_ID: begin
                    if (r_field_count == '0 &&
                        (r_position > tag_end || r_in_byte == '0)) begin
                        n_done = 1'b1;
                        ended  = 1'b1;
                    end else begin
                        n_ident = {r_ident[IDENT_W-9:0], r_in_byte};
                        if (r_field_count == FIELD_LAST_4) begin
                            if (n_ident == i_match_key) begin
                                n_found = 1'b1;
                            end
                            n_field_count  = '0;
                            n_payload_left = '0;
                            n_phase        = PH_SIZE;
                        end else begin
                            n_field_count = r_field_count + 1'b1;
                        end
                    end
                end
                PH_SIZE: begin
                    n_payload_left = size_acc;
                    if (r_field_count == FIELD_LAST_4) begin
                        if (size_acc != '0) begin
                            n_payload_left = size_acc - 1'b1;
                        end
                        n_field_count = '0;
                        n_phase       = PH_FLAGS;
                    end else begin
                        n_field_count = r_field_count + 1'b1;
                    end
                end
                PH_FLAGS: begin
                    if (r_field_count == FIELD_LAST_3) begin
                        n_field_count = '0;
                        n_phase = (r_payload_left != '0) ? PH_DATA : PH_ID;
                    end else begin
                        n_field_count = r_field_count + 1'b1;
                    end
                end
                PH_DATA: begin
                    if (i_show_all || r_ident == i_match_key) begin
                        emit             = 1'b1;
                        res.kind         = KIND_PAYLOAD;
                        res.payload_byte = r_in_byte;
                        res.frame_ident  = r_ident;
                        res.frame_last   = (r_payload_left == TAG_W'(1));
                    end
                    if (r_payload_left <= TAG_W'(1)) begin
                        n_payload_left = '0;
                        n_field_count  = '0;
                        n_phase        = PH_ID;
                    end else begin
                        n_payload_left = r_payload_left - 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_HEAD;
                end
            endcase
            if (ended || r_in_end) begin
                emit          = 1'b1;
                res           = '0;
                res.kind      = KIND_REPORT;
                res.key_found = n_found;
                res.truncated = !ended;
            end
        end

        if (r_in_end) begin
            n_phase        = PH_HEAD;
            n_field_count  = '0;
            n_tag_length   = '0;
            n_position     = '0;
            n_ident        = '0;
            n_payload_left = '0;
            n_found        = 1'b0;
            n_done         = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEAD;
            r_field_count  <= '0;
            r_tag_length   <= '0;
            r_position     <= '0;
            r_ident        <= '0;
            r_payload_left <= '0;
            r_found        <= 1'b0;
            r_done         <= 1'b0;
        end else if (fire) begin
            r_phase        <= n_phase;
            r_field_count  <= n_field_count;
            r_tag_length   <= n_tag_length;
            r_position     <= n_position;
            r_ident        <= n_ident;
            r_payload_left <= n_payload_left;
            r_found        <= n_found;
            r_done         <= n_done;
        end
    end

    assign o_res_valid = fire && emit;
    assign o_res       = res;

`ifndef SYNTHESIS
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_end |=> r_phase == PH_HEAD && r_position == '0 && !r_done)
        else $error("state not cleared after stream end");
    a_done_in_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_phase == PH_ID)
        else $error("parse end outside frame id phase");
    a_data_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_payload_left != '0)
        else $error("data phase with no payload left");
    a_report_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && fire && !r_in_end |-> !o_res_valid)
        else $error("word emitted after parse end");
`endif

endmodule

/* rtl/core/id3fx_out_reg.sv */
// Result register between the parser and the output channel.
module id3fx_out_reg
    import id3fx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_load_ok,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_load_ok = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load_ok) begin
            r_valid <= i_res_valid;
        end
        if (o_load_ok && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

`ifndef SYNTHESIS
    a_report_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.kind == KIND_REPORT |->
            r_res.frame_ident == '0 && r_res.payload_byte == '0 && !r_res.frame_last)
        else $error("report word carries payload fields");
`endif

endmodule

/* rtl/core/id3v2_frame_extractor.sv */
// Top level: ID3v2 tag frame extractor with APB configuration registers.
//  channel | direction | handshake          | word
//  input   | in        | i_valid / o_stall  | i_data_byte, i_stream_end
//  output  | out       | o_valid / i_stall  | o_kind .. o_truncated
//  config  | in        | psel/penable/pready| paddr, pwdata, prdata
// One byte per cycle when not stalled; path: input register, then result register.
// Synchronous active-low reset clears parser state and both registers.
// An output stall holds the result register; the input stalls only once the
// input register also holds a word that cannot move on.
module id3v2_frame_extractor
    import id3fx_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [BYTE_W-1:0]  i_data_byte,
    input  logic               i_stream_end,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_kind,
    output logic [BYTE_W-1:0]  o_payload_byte,
    output logic [IDENT_W-1:0] o_frame_ident,
    output logic               o_frame_last,
    output logic               o_key_found,
    output logic               o_truncated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [IDENT_W-1:0] r_match_key;
    logic               r_show_all;
    logic               cfg_wr;
    logic               load_ok;
    logic               res_valid;
    t_result            res;
    t_result            out_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_key <= '0;
            r_show_all  <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MATCH_KEY) begin
                r_match_key <= pwdata;
            end else begin
                r_show_all <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_MATCH_KEY) ? r_match_key : {31'd0, r_show_all};

    id3fx_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_stream_end (i_stream_end),
        .i_match_key  (r_match_key),
        .i_show_all   (r_show_all),
        .i_load_ok    (load_ok),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    id3fx_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_load_ok   (load_ok),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (out_res)
    );

    assign o_kind         = out_res.kind;
    assign o_payload_byte = out_res.payload_byte;
    assign o_frame_ident  = out_res.frame_ident;
    assign o_frame_last   = out_res.frame_last;
    assign o_key_found    = out_res.key_found;
    assign o_truncated    = out_res.truncated;

endmodule
